[rtl/usid_pkg.sv]
package usid_pkg;

    localparam int DEPTH_DEF     = 16;
    localparam int KEY_WIDTH_DEF = 32;

    localparam int ACTION_W = 1;
    localparam int ITEM_W   = 32;
    localparam int STATUS_W = 2;
    localparam int TOTAL_W  = 5;
    localparam int SLOT_W   = 4;
    localparam int CAP_W    = 5;

    localparam int APB_AW = 3;
    localparam int APB_DW = 32;

    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

    localparam logic [ACTION_W-1:0] ACT_ADD    = 1'b0;
    localparam logic [ACTION_W-1:0] ACT_REMOVE = 1'b1;

    // register index carried in paddr[2]
    localparam logic REG_CAPACITY = 1'b0;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK      = 2'd0,
        ST_DUP     = 2'd1,
        ST_FULL    = 2'd2,
        ST_MISSING = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SEARCH,
        S_DECIDE,
        S_SHIFT,
        S_DONE
    } t_state;

endpackage

[rtl/usid_ram.sv]
module usid_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/usid_cfg.sv]
module usid_cfg (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [usid_pkg::APB_AW-1:0] paddr,
    input  logic [usid_pkg::APB_DW-1:0] pwdata,
    output logic [usid_pkg::APB_DW-1:0] prdata,
    output logic                        pready,
    output logic [usid_pkg::CAP_W-1:0]  o_capacity
);

    import usid_pkg::*;

    logic [CAP_W-1:0] r_capacity;
    logic             w_wr;
    logic             w_sel_cap;

    assign w_sel_cap = (paddr[2] == REG_CAPACITY);
    assign w_wr      = psel & penable & pwrite & w_sel_cap;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity <= CAP_RESET;
        end else if (w_wr) begin
            r_capacity <= pwdata[CAP_W-1:0];
        end
    end

    always_comb begin
        prdata = '0;
        if (w_sel_cap) begin
            prdata = APB_DW'(r_capacity);
        end
    end

    assign pready     = 1'b1;
    assign o_capacity = r_capacity;

endmodule

[rtl/usid_ctrl.sv]
module usid_ctrl #(
    parameter int DEPTH     = usid_pkg::DEPTH_DEF,
    parameter int KEY_WIDTH = usid_pkg::KEY_WIDTH_DEF,
    localparam int IDX_W    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic [usid_pkg::CAP_W-1:0]    i_capacity,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [usid_pkg::ACTION_W-1:0] i_action,
    input  logic [usid_pkg::ITEM_W-1:0]   i_item_key,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [usid_pkg::STATUS_W-1:0] o_status,
    output logic [usid_pkg::TOTAL_W-1:0]  o_entry_total,
    output logic [usid_pkg::SLOT_W-1:0]   o_slot_position,
    output logic                          o_ram_we,
    output logic [IDX_W-1:0]              o_ram_waddr,
    output logic [KEY_WIDTH-1:0]          o_ram_wdata,
    output logic [IDX_W-1:0]              o_ram_raddr,
    input  logic [KEY_WIDTH-1:0]          i_ram_rdata
);

    import usid_pkg::*;

    localparam int CNT_W   = $clog2(DEPTH + 1);
    localparam int CMP_W   = (CNT_W > CAP_W) ? CNT_W : CAP_W;
    localparam int TOT_EXT = (CNT_W > TOTAL_W) ? CNT_W : TOTAL_W;
    localparam int SLT_EXT = (IDX_W > SLOT_W) ? IDX_W : SLOT_W;
    localparam int KEY_EXT = (KEY_WIDTH > ITEM_W) ? KEY_WIDTH : ITEM_W;

    t_state                 r_state;
    t_state                 n_state;
    logic [ACTION_W-1:0]    r_action;
    logic [KEY_WIDTH-1:0]   r_key;
    logic [CNT_W-1:0]       r_cnt;
    logic [CNT_W-1:0]       r_rd;
    logic                   r_pend;
    logic [IDX_W-1:0]       r_pidx;
    logic                   r_hit;
    logic [IDX_W-1:0]       r_hidx;
    t_status                r_st;
    logic [IDX_W-1:0]       r_slot;
    logic                   r_out_vld;
    t_status                r_out_st;
    logic [TOTAL_W-1:0]     r_out_tot;
    logic [SLOT_W-1:0]      r_out_slot;

    logic [KEY_EXT-1:0]     w_key_ext;
    logic [KEY_WIDTH-1:0]   w_key;
    logic                   w_walk;
    logic                   w_issue;
    logic                   w_match;
    logic                   w_drained;
    logic [CMP_W-1:0]       w_cap_ext;
    logic [CMP_W-1:0]       w_depth;
    logic [CMP_W-1:0]       w_cap_eff;
    logic                   w_room;
    logic                   w_take_in;
    logic                   w_load_out;
    logic [TOT_EXT-1:0]     w_tot_ext;
    logic [SLT_EXT-1:0]     w_slot_ext;

    assign w_key_ext = KEY_EXT'(i_item_key);
    assign w_key     = w_key_ext[KEY_WIDTH-1:0];

    // one read per cycle through the ram port, compare of the word read last cycle
    assign w_walk    = (r_state == S_SEARCH) || (r_state == S_SHIFT);
    assign w_issue   = w_walk && (r_rd < r_cnt);
    assign w_match   = r_pend && (i_ram_rdata == r_key);
    assign w_drained = !w_issue && !r_pend;

    assign w_cap_ext = CMP_W'(i_capacity);
    assign w_depth   = CMP_W'(DEPTH);
    assign w_cap_eff = (w_cap_ext < w_depth) ? w_cap_ext : w_depth;
    assign w_room    = (CMP_W'(r_cnt) < w_cap_eff);

    assign w_take_in  = (r_state == S_IDLE) && i_in_valid;
    assign w_load_out = (r_state == S_DONE) && (!r_out_vld || i_out_ready);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_SEARCH;
                end
            end
            S_SEARCH: begin
                if (w_match || w_drained) begin
                    n_state = S_DECIDE;
                end
            end
            S_DECIDE: begin
                if ((r_action == ACT_REMOVE) && r_hit) begin
                    n_state = S_SHIFT;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_SHIFT: begin
                if (w_drained) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (!r_out_vld || i_out_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready  = 1'b0;
        o_ram_we    = 1'b0;
        o_ram_waddr = r_cnt[IDX_W-1:0];
        o_ram_wdata = r_key;
        o_ram_raddr = r_rd[IDX_W-1:0];
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
            end
            S_DECIDE: begin
                o_ram_we = (r_action == ACT_ADD) && !r_hit && w_room;
            end
            S_SHIFT: begin
                // word read from slot i lands in slot i-1
                o_ram_we    = r_pend;
                o_ram_waddr = r_pidx - IDX_W'(1);
                o_ram_wdata = i_ram_rdata;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_cnt     <= '0;
            r_pend    <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_state <= n_state;
            r_pend  <= w_issue;
            if (w_issue) begin
                r_pidx <= r_rd[IDX_W-1:0];
                r_rd   <= r_rd + CNT_W'(1);
            end
            if (w_load_out) begin
                r_out_vld <= 1'b1;
            end else if (r_out_vld && i_out_ready) begin
                r_out_vld <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_take_in) begin
                        r_action <= i_action;
                        r_key    <= w_key;
                        r_rd     <= '0;
                        r_hit    <= 1'b0;
                    end
                end
                S_SEARCH: begin
                    if (w_match) begin
                        r_hit  <= 1'b1;
                        r_hidx <= r_pidx;
                    end
                end
                S_DECIDE: begin
                    if (r_action == ACT_ADD) begin
                        if (r_hit) begin
                            r_st   <= ST_DUP;
                            r_slot <= r_hidx;
                        end else if (w_room) begin
                            r_st   <= ST_OK;
                            r_slot <= r_cnt[IDX_W-1:0];
                            r_cnt  <= r_cnt + CNT_W'(1);
                        end else begin
                            r_st   <= ST_FULL;
                            r_slot <= '0;
                        end
                    end else begin
                        if (r_hit) begin
                            r_st   <= ST_OK;
                            r_slot <= r_hidx;
                            r_rd   <= CNT_W'(r_hidx) + CNT_W'(1);
                        end else begin
                            r_st   <= ST_MISSING;
                            r_slot <= '0;
                        end
                    end
                end
                S_SHIFT: begin
                    if (w_drained) begin
                        r_cnt <= r_cnt - CNT_W'(1);
                    end
                end
                S_DONE: begin
                    if (w_load_out) begin
                        r_out_st   <= r_st;
                        r_out_tot  <= w_tot_ext[TOTAL_W-1:0];
                        r_out_slot <= w_slot_ext[SLOT_W-1:0];
                    end
                end
                default: begin
                end
            endcase
        end
    end

    assign w_tot_ext  = TOT_EXT'(r_cnt);
    assign w_slot_ext = SLT_EXT'(r_slot);

    assign o_out_valid     = r_out_vld;
    assign o_status        = r_out_st;
    assign o_entry_total   = r_out_tot;
    assign o_slot_position = r_out_slot;

endmodule

[rtl/unique_set_insert_delete_top.sv]
// time to o_out_valid grows with the entries held: an add or a miss reads every entry,
// a duplicate stops at its slot, and a remove hit then shifts the entries above it down
// one request at a time: busy from input transfer until the result register loads,
// longer while a result waits; one ram read per cycle sets search and shift
// reset: synchronous active-low clears the entry count, the sequencer and the result
// valid flag and sets the capacity register to 16; the key store is not cleared
module unique_set_insert_delete_top #(
    parameter int DEPTH     = usid_pkg::DEPTH_DEF,
    parameter int KEY_WIDTH = usid_pkg::KEY_WIDTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [usid_pkg::APB_AW-1:0]   paddr,
    input  logic [usid_pkg::APB_DW-1:0]   pwdata,
    output logic [usid_pkg::APB_DW-1:0]   prdata,
    output logic                          pready,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [usid_pkg::ACTION_W-1:0] i_action,
    input  logic [usid_pkg::ITEM_W-1:0]   i_item_key,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [usid_pkg::STATUS_W-1:0] o_status,
    output logic [usid_pkg::TOTAL_W-1:0]  o_entry_total,
    output logic [usid_pkg::SLOT_W-1:0]   o_slot_position
);

    import usid_pkg::*;

    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [CAP_W-1:0]     w_capacity;
    logic                 w_ram_we;
    logic [IDX_W-1:0]     w_ram_waddr;
    logic [KEY_WIDTH-1:0] w_ram_wdata;
    logic [IDX_W-1:0]     w_ram_raddr;
    logic [KEY_WIDTH-1:0] w_ram_rdata;

    usid_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .o_capacity (w_capacity)
    );

    usid_ram #(
        .WIDTH (KEY_WIDTH),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (w_ram_waddr),
        .i_wdata (w_ram_wdata),
        .i_raddr (w_ram_raddr),
        .o_rdata (w_ram_rdata)
    );

    usid_ctrl #(
        .DEPTH     (DEPTH),
        .KEY_WIDTH (KEY_WIDTH)
    ) u_ctrl (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_capacity      (w_capacity),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_action        (i_action),
        .i_item_key      (i_item_key),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_status        (o_status),
        .o_entry_total   (o_entry_total),
        .o_slot_position (o_slot_position),
        .o_ram_we        (w_ram_we),
        .o_ram_waddr     (w_ram_waddr),
        .o_ram_wdata     (w_ram_wdata),
        .o_ram_raddr     (w_ram_raddr),
        .i_ram_rdata     (w_ram_rdata)
    );

endmodule
